FILE: hdl/e2q_pkg.sv
package e2q_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;
    localparam int ANGLE_W          = 16;
    localparam int QUAT_W           = 16;
    localparam int CW               = 33;
    localparam int TW               = 18;
    localparam int P1W              = 2 * TW;
    localparam int P2W              = 3 * TW;
    localparam int SW               = P2W + 2;

    localparam int AX_PITCH = 0;
    localparam int AX_YAW   = 1;
    localparam int AX_ROLL  = 2;
    localparam int N_AXES   = 3;

    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd25736;
    localparam logic signed [QUAT_W-1:0]  Q_LIMIT     = 16'sd16384;
    localparam logic signed [CW-1:0]      GAIN_Q30    = 33'sd652032874;
    localparam logic signed [CW-1:0]      RND_Q15     = 33'sd16384;

    localparam logic signed [CW-1:0] ATAN_Q30 [0:TABLE_LEN-1] = '{
        33'sd843314856, 33'sd497837829, 33'sd263043836, 33'sd133525158,
        33'sd67021686,  33'sd33543515,  33'sd16775850,  33'sd8388437,
        33'sd4194282,   33'sd2097149,   33'sd1048575,   33'sd524287,
        33'sd262143,    33'sd131071,    33'sd65535,     33'sd32767,
        33'sd16383,     33'sd8191,      33'sd4095,      33'sd2047,
        33'sd1023,      33'sd511,       33'sd255,       33'sd127
    };

    typedef struct packed {
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] yaw_angle;
        logic signed [ANGLE_W-1:0] roll_angle;
    } angle_item_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
    } quat_item_t;

endpackage

FILE: hdl/euler_to_quaternion.sv
// channel   handshake                  payload
// angle     angle_valid / angle_stall  angle: pitch_angle, yaw_angle, roll_angle
// quat      quat_valid / quat_stall    quat: quat_w, quat_x, quat_y, quat_z
//
// one item per cycle while angle_stall is low
// the pipeline is the clamp stage, one unrolled cordic stage per step, then round,
// two product stages and the output register
// rst_n clears all valid bits asynchronously; the pipeline then holds no item
// a stalled result parks in a one-item skid register; angle_stall is that register's full flag
module euler_to_quaternion #(
    parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 angle_valid,
    output logic                 angle_stall,
    input  e2q_pkg::angle_item_t angle,
    output logic                 quat_valid,
    input  logic                 quat_stall,
    output e2q_pkg::quat_item_t  quat
);
    import e2q_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    logic                  en;
    logic                  cv_reg [0:NSTEP];
    logic signed [CW-1:0]  x_reg  [0:NSTEP][0:N_AXES-1];
    logic signed [CW-1:0]  y_reg  [0:NSTEP][0:N_AXES-1];
    logic signed [CW-1:0]  z_reg  [0:NSTEP][0:N_AXES-1];

    logic                  rv_reg;
    logic signed [TW-1:0]  c_reg  [0:N_AXES-1];
    logic signed [TW-1:0]  s_reg  [0:N_AXES-1];

    logic                  p1v_reg;
    logic signed [P1W-1:0] cycp_reg, sysp_reg, cysp_reg, sycp_reg;
    logic signed [TW-1:0]  cr1_reg, sr1_reg;

    logic                  p2v_reg;
    logic signed [P2W-1:0] pw0_reg, pw1_reg, px0_reg, px1_reg;
    logic signed [P2W-1:0] py0_reg, py1_reg, pz0_reg, pz1_reg;

    quat_item_t            result;
    logic                  quat_valid_reg;
    quat_item_t            quat_reg;
    logic                  skid_valid_reg;
    quat_item_t            skid_reg;
    logic                  out_take;

    logic signed [ANGLE_W-1:0] raw [0:N_AXES-1];

    function automatic logic signed [CW-1:0] clamp_z(input logic signed [ANGLE_W-1:0] a);
        logic signed [ANGLE_W-1:0] c;
        c = a;
        if (a > ANGLE_LIMIT)
            c = ANGLE_LIMIT;
        else if (a < -ANGLE_LIMIT)
            c = -ANGLE_LIMIT;
        return {c[ANGLE_W-1], c, 16'b0};
    endfunction

    function automatic logic signed [TW-1:0] round_q15(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        t = v + RND_Q15;
        return t[CW-1:CW-TW];
    endfunction

    function automatic logic signed [QUAT_W-1:0] finish(
        input logic signed [P2W-1:0] a,
        input logic signed [P2W-1:0] b,
        input logic                  neg_b
    );
        logic signed [SW-1:0]    s;
        logic signed [SW-32:0]   v;
        logic signed [QUAT_W-1:0] r;
        s = neg_b ? (SW'(a) - SW'(b)) : (SW'(a) + SW'(b));
        s = s + (SW'(1) <<< 30);
        v = s[SW-1:31];
        if (v > (SW-31)'(Q_LIMIT))
            r = Q_LIMIT;
        else if (v < -(SW-31)'(Q_LIMIT))
            r = -Q_LIMIT;
        else
            r = v[QUAT_W-1:0];
        return r;
    endfunction

    assign en          = !skid_valid_reg;
    assign angle_stall = skid_valid_reg;
    assign out_take    = quat_valid_reg && !quat_stall;

    assign raw[AX_PITCH] = angle.pitch_angle;
    assign raw[AX_YAW]   = angle.yaw_angle;
    assign raw[AX_ROLL]  = angle.roll_angle;

    // clamp and scale into cordic start vector
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            cv_reg[0] <= 1'b0;
        else if (en)
            cv_reg[0] <= angle_valid;
    end

    always_ff @(posedge clk) begin
        if (en) begin
            for (int a = 0; a < N_AXES; a++) begin
                x_reg[0][a] <= GAIN_Q30;
                y_reg[0][a] <= '0;
                z_reg[0][a] <= clamp_z(raw[a]);
            end
        end
    end

    // one rotation per stage
    for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n)
                cv_reg[i+1] <= 1'b0;
            else if (en)
                cv_reg[i+1] <= cv_reg[i];
        end

        always_ff @(posedge clk) begin
            if (en) begin
                for (int a = 0; a < N_AXES; a++) begin
                    if (!z_reg[i][a][CW-1]) begin
                        x_reg[i+1][a] <= x_reg[i][a] - (y_reg[i][a] >>> i);
                        y_reg[i+1][a] <= y_reg[i][a] + (x_reg[i][a] >>> i);
                        z_reg[i+1][a] <= z_reg[i][a] - ATAN_Q30[i];
                    end
                    else begin
                        x_reg[i+1][a] <= x_reg[i][a] + (y_reg[i][a] >>> i);
                        y_reg[i+1][a] <= y_reg[i][a] - (x_reg[i][a] >>> i);
                        z_reg[i+1][a] <= z_reg[i][a] + ATAN_Q30[i];
                    end
                end
            end
        end
    end

    // valid bits of the tail stages
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            rv_reg  <= 1'b0;
            p1v_reg <= 1'b0;
            p2v_reg <= 1'b0;
        end
        else if (en)
        begin
            rv_reg  <= cv_reg[NSTEP];
            p1v_reg <= rv_reg;
            p2v_reg <= p1v_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            for (int a = 0; a < N_AXES; a++) begin
                c_reg[a] <= round_q15(x_reg[NSTEP][a]);
                s_reg[a] <= round_q15(y_reg[NSTEP][a]);
            end
            cycp_reg <= P1W'(c_reg[AX_YAW]) * P1W'(c_reg[AX_PITCH]);
            sysp_reg <= P1W'(s_reg[AX_YAW]) * P1W'(s_reg[AX_PITCH]);
            cysp_reg <= P1W'(c_reg[AX_YAW]) * P1W'(s_reg[AX_PITCH]);
            sycp_reg <= P1W'(s_reg[AX_YAW]) * P1W'(c_reg[AX_PITCH]);
            cr1_reg  <= c_reg[AX_ROLL];
            sr1_reg  <= s_reg[AX_ROLL];
            pw0_reg  <= P2W'(cycp_reg) * P2W'(cr1_reg);
            pw1_reg  <= P2W'(sysp_reg) * P2W'(sr1_reg);
            px0_reg  <= P2W'(cysp_reg) * P2W'(cr1_reg);
            px1_reg  <= P2W'(sycp_reg) * P2W'(sr1_reg);
            py0_reg  <= P2W'(sycp_reg) * P2W'(cr1_reg);
            py1_reg  <= P2W'(cysp_reg) * P2W'(sr1_reg);
            pz0_reg  <= P2W'(cycp_reg) * P2W'(sr1_reg);
            pz1_reg  <= P2W'(sysp_reg) * P2W'(cr1_reg);
        end
    end

    always_comb begin
        result.quat_w = finish(pw0_reg, pw1_reg, 1'b0);
        result.quat_x = finish(px0_reg, px1_reg, 1'b0);
        result.quat_y = finish(py0_reg, py1_reg, 1'b1);
        result.quat_z = finish(pz0_reg, pz1_reg, 1'b1);
    end

    // output register and skid
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            quat_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (p2v_reg)
        begin
            if (quat_valid_reg && !out_take)
                skid_valid_reg <= 1'b1;
            else
                quat_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            quat_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (skid_valid_reg) begin
            if (out_take)
                quat_reg <= skid_reg;
        end
        else if (p2v_reg) begin
            if (quat_valid_reg && !out_take)
                skid_reg <= result;
            else
                quat_reg <= result;
        end
    end

    assign quat_valid = quat_valid_reg;
    assign quat       = quat_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> quat_valid_reg)
        else $error("skid holds an item while the output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(quat_valid_reg && quat_stall && p2v_reg))
        else $error("skid filled without a stalled result and a finished item");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (angle_valid && !angle_stall) |=> cv_reg[0])
        else $error("accepted item did not enter the pipeline");

    a_quat_range: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid |-> (quat.quat_w <= Q_LIMIT && quat.quat_w >= -Q_LIMIT
            && quat.quat_x <= Q_LIMIT && quat.quat_x >= -Q_LIMIT
            && quat.quat_y <= Q_LIMIT && quat.quat_y >= -Q_LIMIT
            && quat.quat_z <= Q_LIMIT && quat.quat_z >= -Q_LIMIT))
        else $error("quaternion component outside the unit range");

endmodule

FILE: tb/tb_euler_to_quaternion.sv
module tb_euler_to_quaternion;

    timeunit 1ns;
    timeprecision 1ps;

    import e2q_pkg::*;

    localparam int     STEPS        = CORDIC_STEPS_DEF;
    localparam int     ATAN_LEN     = 24;
    localparam longint START_X      = 64'sd652032874;
    localparam longint ANGLE_MAX    = 64'sd25736;
    localparam longint Q14_MAX      = 64'sd16384;
    localparam int     RANDOM_ITEMS = 1930;
    localparam int     LONG_HOLD    = 300;

    localparam longint ATAN_TAB [0:ATAN_LEN-1] = '{
        64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
        64'sd67021686,  64'sd33543515,  64'sd16775850,  64'sd8388437,
        64'sd4194282,   64'sd2097149,   64'sd1048575,   64'sd524287,
        64'sd262143,    64'sd131071,    64'sd65535,     64'sd32767,
        64'sd16383,     64'sd8191,      64'sd4095,      64'sd2047,
        64'sd1023,      64'sd511,       64'sd255,       64'sd127
    };

    typedef struct {
        bit          drain;
        int          gap;
        angle_item_t item;
    } angle_job_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        angle_valid = 1'b0;
    logic        angle_stall;
    angle_item_t angle       = '0;
    logic        quat_valid;
    logic        quat_stall  = 1'b0;
    quat_item_t  quat;

    angle_job_t angle_jobs[$];
    quat_item_t predicted_quats[$];

    logic angle_fire     = 1'b0;
    int   gap_left       = 0;
    int   hold_left      = 0;
    bit   long_hold_done = 1'b0;
    int   stall_cycles   = 0;
    int   n_accepted     = 0;
    int   n_fail         = 0;

    euler_to_quaternion u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .angle_valid (angle_valid),
        .angle_stall (angle_stall),
        .angle       (angle),
        .quat_valid  (quat_valid),
        .quat_stall  (quat_stall),
        .quat        (quat)
    );

    always #4 clk = ~clk;

    // sine and cosine of half the clamped angle, both in Q.15
    function automatic void half_sin_cos(input logic signed [15:0] angle_in,
                                         output longint s15, output longint c15);
        longint a;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        int     i;
        a = angle_in;
        if (a > ANGLE_MAX)
            a = ANGLE_MAX;
        if (a < -ANGLE_MAX)
            a = -ANGLE_MAX;
        x = START_X;
        y = 0;
        z = a * 65536;
        for (i = 0; i < STEPS && i < ATAN_LEN; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TAB[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TAB[i];
            end
        end
        c15 = (x + 64'sd16384) >>> 15;
        s15 = (y + 64'sd16384) >>> 15;
    endfunction

    function automatic logic signed [15:0] to_q14(input longint sum45);
        longint v;
        v = (sum45 + 64'sd1073741824) >>> 31;
        if (v > Q14_MAX)
            v = Q14_MAX;
        if (v < -Q14_MAX)
            v = -Q14_MAX;
        return 16'(v);
    endfunction

    function automatic quat_item_t predict_quat(input angle_item_t a);
        longint     sp;
        longint     cp;
        longint     sy;
        longint     cy;
        longint     sr;
        longint     cr;
        quat_item_t q;
        half_sin_cos(a.pitch_angle, sp, cp);
        half_sin_cos(a.yaw_angle, sy, cy);
        half_sin_cos(a.roll_angle, sr, cr);
        q.quat_w = to_q14(cy * cp * cr + sy * sp * sr);
        q.quat_x = to_q14(cy * sp * cr + sy * cp * sr);
        q.quat_y = to_q14(sy * cp * cr - cy * sp * sr);
        q.quat_z = to_q14(cy * cp * sr - sy * sp * cr);
        return q;
    endfunction

    // mostly short, now and then long
    function automatic int rand_gap();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return 0;
        if (sel < 90)
            return $urandom_range(3, 1);
        if (sel < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic signed [15:0] rand_angle();
        int sel;
        int v;
        sel = $urandom_range(9);
        if (sel < 6)
            v = int'($urandom_range(51472)) - 25736;
        else if (sel < 7)
            v = int'($urandom_range(65535));
        else if (sel < 8)
            v = (($urandom_range(1) == 1) ? 25736 : -25736) + int'($urandom_range(4)) - 2;
        else if (sel < 9)
            v = int'($urandom_range(64)) - 32;
        else
            v = ($urandom_range(1) == 1) ? 32767 - int'($urandom_range(7000))
                                         : -32768 + int'($urandom_range(7000));
        return 16'(v);
    endfunction

    task automatic add_item(input int p, input int y, input int r, input int gap);
        angle_job_t job;
        job.drain = 1'b0;
        job.gap = gap;
        job.item.pitch_angle = 16'(p);
        job.item.yaw_angle = 16'(y);
        job.item.roll_angle = 16'(r);
        angle_jobs.push_back(job);
    endtask

    task automatic add_drain();
        angle_job_t job;
        job.drain = 1'b1;
        job.gap = 0;
        job.item = '0;
        angle_jobs.push_back(job);
    endtask

    // sender
    always @(negedge clk)
    begin : drive_angle
        logic        nv;
        angle_item_t ni;
        angle_job_t  job;
        nv = angle_valid;
        ni = angle;
        if (rst_n && (!angle_valid || angle_fire))
        begin
            nv = 1'b0;
            if (gap_left > 0)
                gap_left = gap_left - 1;
            else if (angle_jobs.size() > 0)
            begin
                if (angle_jobs[0].drain)
                begin
                    if (predicted_quats.size() == 0)
                        job = angle_jobs.pop_front();
                end
                else
                begin
                    job = angle_jobs.pop_front();
                    nv = 1'b1;
                    ni = job.item;
                    gap_left = job.gap;
                end
            end
        end
        angle_valid <= nv;
        angle <= ni;
    end

    // receiver
    always @(negedge clk)
    begin
        stall_cycles = stall_cycles + 1;
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            quat_stall <= 1'b1;
        end
        else if (!long_hold_done && n_accepted >= 700)
        begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            quat_stall <= 1'b1;
        end
        else if ((stall_cycles / 400) % 3 == 0)
            quat_stall <= 1'b0;
        else
        begin
            hold_left = rand_gap();
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                quat_stall <= 1'b1;
            end
            else
                quat_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : monitor
        quat_item_t exp_q;
        angle_fire <= rst_n && angle_valid && !angle_stall;
        if (rst_n)
        begin
            if (angle_valid && !angle_stall)
            begin
                predicted_quats.push_back(predict_quat(angle));
                n_accepted = n_accepted + 1;
            end
            if (quat_valid && !quat_stall)
            begin
                if (predicted_quats.size() == 0)
                begin
                    $error("quat item with no prediction: %0d %0d %0d %0d",
                           quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z);
                    n_fail = n_fail + 1;
                end
                else
                begin
                    exp_q = predicted_quats.pop_front();
                    if (quat.quat_w !== exp_q.quat_w)
                    begin
                        $error("quat_w expected %0d got %0d", exp_q.quat_w, quat.quat_w);
                        n_fail = n_fail + 1;
                    end
                    if (quat.quat_x !== exp_q.quat_x)
                    begin
                        $error("quat_x expected %0d got %0d", exp_q.quat_x, quat.quat_x);
                        n_fail = n_fail + 1;
                    end
                    if (quat.quat_y !== exp_q.quat_y)
                    begin
                        $error("quat_y expected %0d got %0d", exp_q.quat_y, quat.quat_y);
                        n_fail = n_fail + 1;
                    end
                    if (quat.quat_z !== exp_q.quat_z)
                    begin
                        $error("quat_z expected %0d got %0d", exp_q.quat_z, quat.quat_z);
                        n_fail = n_fail + 1;
                    end
                end
            end
        end
    end

    initial
    begin
        int k;
        int g;

        // extremes, clamping, quarter turns and zero
        add_item(0, 0, 0, 0);
        add_item(25736, 25736, 25736, 1);
        add_item(-25736, -25736, -25736, 0);
        add_item(32767, 32767, 32767, 0);
        add_item(-32768, -32768, -32768, 2);
        add_item(25737, -25737, 0, 0);
        add_item(25735, -25735, 1, 0);
        add_item(-1, -1, -1, 1);
        add_item(1, 1, 1, 0);
        add_item(12868, 0, 0, 0);
        add_item(0, 12868, 0, 0);
        add_item(0, 0, 12868, 3);
        add_item(-12868, 12868, -12868, 0);
        add_item(25736, 0, 0, 0);
        add_item(0, 25736, 0, 0);
        add_item(0, 0, 25736, 1);
        add_item(-32768, 32767, 25736, 0);
        add_item(21845, -21846, 0, 0);
        add_item(6434, -6434, 19302, 0);
        add_item(-25736, 25736, -1, 0);
        add_item(30000, -30000, 100, 0);
        add_drain();

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == 300 || k == 1400)
                add_drain();
            if (k >= 600 && k < 1100)
                g = 0;
            else if ((k / 150) % 3 == 0)
                g = 0;
            else
                g = rand_gap();
            add_item(rand_angle(), rand_angle(), rand_angle(), g);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (angle_jobs.size() > 0 || angle_valid)
            @(posedge clk);
        while (predicted_quats.size() > 0)
            @(posedge clk);
        repeat (STEPS + 12) @(posedge clk);

        if (n_fail == 0)
            $display("euler_to_quaternion: match");
        else
            $display("euler_to_quaternion: mismatch");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("euler_to_quaternion: mismatch");
        $finish;
    end

endmodule

FILE: euler_to_quaternion.f
hdl/e2q_pkg.sv
hdl/euler_to_quaternion.sv
tb/tb_euler_to_quaternion.sv
